// ===== rtl/sst_pkg.sv =====
// shared types and codes for the sorted set search and insert block
`default_nettype none

package sst_pkg;

	// fixed widths of the result fields and of the key and value ports
	localparam int POS_W   = 7;
	localparam int CNT_W   = 7;
	localparam int RVAL_W  = 32;
	localparam int PORT_W  = 32;

	// request kinds
	localparam logic KIND_LOOKUP = 1'b0;
	localparam logic KIND_INSERT = 1'b1;

	// register index of the compare mode register
	localparam logic REG_SIGNED_CMP = 1'b0;

	typedef enum logic [1:0] {
		STAT_OK   = 2'd0,
		STAT_DUP  = 2'd1,
		STAT_FULL = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PROBE,
		ST_CMP,
		ST_SHIFT,
		ST_PUT,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic                found;
		logic [POS_W-1:0]    position;
		logic [RVAL_W-1:0]   stored_value;
		status_t             status;
		logic [CNT_W-1:0]    entry_count;
	} rsp_t;

endpackage

`default_nettype wire

// ===== rtl/sst_store.sv =====
// entry memory: one write port, one registered read port
`default_nettype none

module sst_store #(
	parameter int DEPTH = 64,
	parameter int DW    = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [DW-1:0]            wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [DW-1:0]            rdata
);

	logic [DW-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/sst_engine.sv =====
// search and insert sequencer with the shared key comparator
`default_nettype none

module sst_engine import sst_pkg::*; #(
	parameter int DEPTH       = 64,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic                   kind,
	input  wire logic [KEY_WIDTH-1:0]   key,
	input  wire logic [VALUE_WIDTH-1:0] value,
	input  wire logic                   signed_compare,
	input  wire logic                   ack,
	output      logic                   idle,
	output      logic                   done,
	output      rsp_t                   res
);

	localparam int AW  = $clog2(DEPTH);
	localparam int CW  = $clog2(DEPTH + 1);
	localparam int DW  = KEY_WIDTH + VALUE_WIDTH;
	localparam int PW  = (CW > POS_W) ? CW : POS_W;
	localparam int VXW = (VALUE_WIDTH > RVAL_W) ? VALUE_WIDTH : RVAL_W;
	localparam logic [KEY_WIDTH-1:0] KEY_MSB = ~({KEY_WIDTH{1'b1}} >> 1);

	state_t               state_q, state_d;
	logic                 kind_q;
	logic [KEY_WIDTH-1:0] key_q;
	logic [VALUE_WIDTH-1:0] val_q;
	logic [CW-1:0]        lo_q, hi_q, count_q, pos_q, ptr_q;
	logic                 hit_q;
	logic [VALUE_WIDTH-1:0] hval_q;
	status_t              status_q;
	logic                 wpend_q;
	logic [AW-1:0]        waddr_q;

	logic [CW:0]          sum;
	logic [CW-1:0]        mid;
	logic [CW-1:0]        ptr_m1;
	logic                 range_open;
	logic                 full;
	logic [DW-1:0]        rdata;
	logic [KEY_WIDTH-1:0] rkey, tgt_ord, prb_ord;
	logic                 lt, gt;
	logic                 we;
	logic [AW-1:0]        waddr, raddr;
	logic [DW-1:0]        wdata;
	logic [PW-1:0]        pos_ext, cnt_ext;
	logic [VXW-1:0]       hval_ext;

	// probe index and bounds
	assign sum        = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid        = sum[CW:1];
	assign ptr_m1     = ptr_q - CW'(1);
	assign range_open = lo_q < hi_q;
	assign full       = count_q == CW'(DEPTH);

	// shared comparator in the selected key order
	assign rkey    = rdata[DW-1 -: KEY_WIDTH];
	assign tgt_ord = key_q ^ ({KEY_WIDTH{signed_compare}} & KEY_MSB);
	assign prb_ord = rkey ^ ({KEY_WIDTH{signed_compare}} & KEY_MSB);
	assign lt      = tgt_ord < prb_ord;
	assign gt      = tgt_ord > prb_ord;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:  if (start) state_d = ST_PROBE;
			ST_PROBE: begin
				if (range_open) begin
					state_d = ST_CMP;
				end else if (kind_q == KIND_INSERT && !full) begin
					state_d = ST_SHIFT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_CMP:   state_d = (!lt && !gt) ? ST_DONE : ST_PROBE;
			ST_SHIFT: if (ptr_q == pos_q && !wpend_q) state_d = ST_PUT;
			ST_PUT:   state_d = ST_DONE;
			ST_DONE:  if (ack) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	// memory port and handshake outputs
	always_comb begin
		idle  = 1'b0;
		done  = 1'b0;
		we    = 1'b0;
		waddr = waddr_q;
		wdata = rdata;
		raddr = mid[AW-1:0];
		unique case (state_q)
			ST_IDLE:  idle = 1'b1;
			ST_PROBE: raddr = mid[AW-1:0];
			ST_CMP:   raddr = mid[AW-1:0];
			ST_SHIFT: begin
				raddr = ptr_m1[AW-1:0];
				we    = wpend_q;
			end
			ST_PUT: begin
				we    = 1'b1;
				waddr = pos_q[AW-1:0];
				wdata = {key_q, val_q};
			end
			ST_DONE:  done = 1'b1;
			default:  idle = 1'b0;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			wpend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_PUT) begin
				count_q <= count_q + CW'(1);
			end
			if (state_q == ST_SHIFT) begin
				wpend_q <= ptr_q != pos_q;
			end
		end
	end

	// search and shift datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					kind_q <= kind;
					key_q  <= key;
					val_q  <= value;
					lo_q   <= '0;
					hi_q   <= count_q;
					hit_q  <= 1'b0;
				end
			end
			ST_PROBE: begin
				if (!range_open) begin
					pos_q <= lo_q;
					ptr_q <= count_q;
					if (kind_q == KIND_INSERT && full) begin
						status_q <= STAT_FULL;
					end else begin
						status_q <= STAT_OK;
					end
				end
			end
			ST_CMP: begin
				if (lt) begin
					hi_q <= mid;
				end else if (gt) begin
					lo_q <= mid + CW'(1);
				end else begin
					hit_q    <= 1'b1;
					pos_q    <= mid;
					hval_q   <= rdata[VALUE_WIDTH-1:0];
					status_q <= (kind_q == KIND_INSERT) ? STAT_DUP : STAT_OK;
				end
			end
			ST_SHIFT: begin
				if (ptr_q != pos_q) begin
					waddr_q <= ptr_q[AW-1:0];
					ptr_q   <= ptr_m1;
				end
			end
			default: ;
		endcase
	end

	sst_store #(
		.DEPTH (DEPTH),
		.DW    (DW)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// result word
	assign pos_ext  = PW'(pos_q);
	assign cnt_ext  = PW'(count_q);
	assign hval_ext = VXW'(hval_q);

	always_comb begin
		res.found        = hit_q;
		res.position     = pos_ext[POS_W-1:0];
		res.stored_value = hit_q ? hval_ext[RVAL_W-1:0] : '0;
		res.status       = status_q;
		res.entry_count  = cnt_ext[CNT_W-1:0];
	end

endmodule

`default_nettype wire

// ===== rtl/sorted_set_search_insert.sv =====
// sorted key/value set with binary search lookup and ordered insert
// Requests arrive on the req channel (kind, key, value) with req_valid and
// req_stall; one result word leaves on the rsp channel per request.
// req_stall is high while a request is being worked on; a new request is
// taken as soon as the previous result has moved into the output register.
// A lookup runs the probes of the binary search, each a read of the entry
// memory, then a compare; at most clog2(count+1) probes, 7 for 64 entries.
// An insert of a new key adds the shift of the k higher entries, one entry a
// cycle through the single memory write port, and the write of the new entry.
// Full or duplicate inserts change nothing.
// The output register holds its word while rsp_stall is high; the engine
// then waits with its finished result and req_stall stays high.
// Reset empties the set (count to zero), clears rsp_valid and selects
// unsigned compare; the entry memory itself is not cleared.
// Register 0 at byte address 0, bit 0: signed_compare.
`default_nettype none

module sorted_set_search_insert import sst_pkg::*; #(
	parameter int DEPTH       = 64,
	parameter int KEY_WIDTH   = 32,
	parameter int VALUE_WIDTH = 32
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	// configuration port
	input  wire logic                psel,
	input  wire logic                penable,
	input  wire logic                pwrite,
	input  wire logic [2:0]          paddr,
	input  wire logic [31:0]         pwdata,
	output      logic [31:0]         prdata,
	output      logic                pready,
	// request channel
	input  wire logic                req_valid,
	output      logic                req_stall,
	input  wire logic                kind,
	input  wire logic [PORT_W-1:0]   key,
	input  wire logic [PORT_W-1:0]   value,
	// result channel
	output      logic                rsp_valid,
	input  wire logic                rsp_stall,
	output      logic                found,
	output      logic [POS_W-1:0]    position,
	output      logic [RVAL_W-1:0]   stored_value,
	output      logic [1:0]          status,
	output      logic [CNT_W-1:0]    entry_count
);

	localparam int KXW = (KEY_WIDTH > PORT_W) ? KEY_WIDTH : PORT_W;
	localparam int VXW = (VALUE_WIDTH > PORT_W) ? VALUE_WIDTH : PORT_W;

	logic                   signed_cmp_q;
	logic                   cfg_wr;
	logic                   eng_idle, eng_done, eng_ack, start;
	rsp_t                   eng_res, rsp_q;
	logic                   rsp_valid_q;
	logic [KXW-1:0]         key_ext;
	logic [VXW-1:0]         val_ext;

	// configuration register
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			signed_cmp_q <= 1'b0;
		end else if (cfg_wr && paddr[2] == REG_SIGNED_CMP) begin
			signed_cmp_q <= pwdata[0];
		end
	end

	assign prdata = (paddr[2] == REG_SIGNED_CMP) ? {31'd0, signed_cmp_q} : 32'd0;

	// request acceptance
	assign req_stall = !eng_idle;
	assign start     = req_valid && !req_stall;
	assign key_ext   = KXW'(key);
	assign val_ext   = VXW'(value);

	sst_engine #(
		.DEPTH       (DEPTH),
		.KEY_WIDTH   (KEY_WIDTH),
		.VALUE_WIDTH (VALUE_WIDTH)
	) u_engine (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.kind           (kind),
		.key            (key_ext[KEY_WIDTH-1:0]),
		.value          (val_ext[VALUE_WIDTH-1:0]),
		.signed_compare (signed_cmp_q),
		.ack            (eng_ack),
		.idle           (eng_idle),
		.done           (eng_done),
		.res            (eng_res)
	);

	// output register for the result word
	assign eng_ack = eng_done && (!rsp_valid_q || !rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (eng_ack) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (eng_ack) begin
			rsp_q <= eng_res;
		end
	end

	assign rsp_valid    = rsp_valid_q;
	assign found        = rsp_q.found;
	assign position     = rsp_q.position;
	assign stored_value = rsp_q.stored_value;
	assign status       = rsp_q.status;
	assign entry_count  = rsp_q.entry_count;

	// a taken word keeps the engine busy in the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> req_stall)
		else $error("request taken but engine not busy");

	// a full refusal never reports a match
	a_full_not_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_FULL |-> !found)
		else $error("full status with a match");

	// no match means no value returned
	a_miss_zero_value: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !found |-> stored_value == '0)
		else $error("value returned without a match");

	// a duplicate is always a match
	a_dup_found: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && status == STAT_DUP |-> found)
		else $error("duplicate status without a match");

endmodule

`default_nettype wire

// ===== tb/sst_checker.sv =====
// result checker for the sorted set block: predicts every word and compares it
module sst_checker import sst_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	input  logic        pready,
	input  logic        req_valid,
	input  logic        req_stall,
	input  logic        kind,
	input  logic [31:0] key,
	input  logic [31:0] value,
	input  logic        rsp_valid,
	input  logic        rsp_stall,
	input  logic        found,
	input  logic [6:0]  position,
	input  logic [31:0] stored_value,
	input  logic [1:0]  status,
	input  logic [6:0]  entry_count,
	output int          errors,
	output int          answers_left,
	output int          n_words,
	output int          n_hits,
	output int          n_added,
	output int          n_dup,
	output int          n_full
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SET_DEPTH = 64;

	// own copy of the set and of the compare mode
	logic [31:0] set_keys [SET_DEPTH];
	logic [31:0] set_vals [SET_DEPTH];
	int unsigned set_count;
	logic        cmp_signed;
	rsp_t        answers_due [$];
	rsp_t        want;

	// flip the sign bit so that an unsigned compare gives two's complement order
	function automatic logic [31:0] rank(logic [31:0] k, logic signed_mode);
		return signed_mode ? (k ^ 32'h8000_0000) : k;
	endfunction

	// binary search, then insert where the key is new and there is room
	task automatic search_set(input logic w_kind, input logic [31:0] w_key,
			input logic [31:0] w_val, output rsp_t ans);
		int unsigned lo, hi, mid, pos, i;
		logic        hit;
		logic [31:0] target, probe, held;
		status_t     st;
		lo = 0;
		hi = set_count;
		hit = 1'b0;
		pos = 0;
		held = '0;
		st = STAT_OK;
		target = rank(w_key, cmp_signed);
		while (lo < hi && !hit) begin
			mid = (lo + hi) / 2;
			probe = rank(set_keys[mid], cmp_signed);
			if (target < probe) begin
				hi = mid;
			end else if (target > probe) begin
				lo = mid + 1;
			end else begin
				hit = 1'b1;
				pos = mid;
			end
		end
		if (!hit)
			pos = lo;
		if (hit) begin
			held = set_vals[pos];
			if (w_kind == KIND_INSERT)
				st = STAT_DUP;
		end else if (w_kind == KIND_INSERT) begin
			if (set_count >= SET_DEPTH) begin
				st = STAT_FULL;
			end else begin
				for (i = set_count; i > pos; i--) begin
					set_keys[i] = set_keys[i-1];
					set_vals[i] = set_vals[i-1];
				end
				set_keys[pos] = w_key;
				set_vals[pos] = w_val;
				set_count++;
			end
		end
		ans.found        = hit;
		ans.position     = 7'(pos);
		ans.stored_value = held;
		ans.status       = st;
		ans.entry_count  = 7'(set_count);
	endtask

	task automatic check_field(input string what, input logic [31:0] want_v,
			input logic [31:0] got_v);
		if (want_v !== got_v) begin
			$display("%0t ns: %s expected %h got %h", $time, what, want_v, got_v);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_count = 0;
			cmp_signed = 1'b0;
			answers_due.delete();
			answers_left = 0;
			errors = 0;
			n_words = 0;
			n_hits = 0;
			n_added = 0;
			n_dup = 0;
			n_full = 0;
		end else begin
			// register writes; other addresses hit no register
			if (psel && penable && pwrite && pready && (paddr >> 2) == REG_SIGNED_CMP)
				cmp_signed = pwdata[0];

			// outgoing word against the oldest prediction
			if (rsp_valid && !rsp_stall) begin
				if (answers_due.size() == 0) begin
					$display("%0t ns: unexpected word found %b position %0d value %h status %0d count %0d",
						$time, found, position, stored_value, status, entry_count);
					errors++;
				end else begin
					want = answers_due.pop_front();
					check_field("found", 32'(want.found), 32'(found));
					check_field("position", 32'(want.position), 32'(position));
					check_field("stored_value", want.stored_value, stored_value);
					check_field("status", 32'(want.status), 32'(status));
					check_field("entry_count", 32'(want.entry_count), 32'(entry_count));
				end
			end

			// incoming word: predict and queue
			if (req_valid && !req_stall) begin
				search_set(kind, key, value, want);
				answers_due.push_back(want);
				n_words++;
				if (want.found && kind == KIND_LOOKUP)
					n_hits++;
				case (want.status)
					STAT_DUP: n_dup++;
					STAT_FULL: n_full++;
					default: if (kind == KIND_INSERT) n_added++;
				endcase
			end
			answers_left = answers_due.size();
		end
	end

endmodule

// ===== tb/tb_sorted_set_search_insert.sv =====
// stimulus and verdict for the sorted set search and insert block
module tb_sorted_set_search_insert import sst_pkg::*; ();
	timeunit 1ns;
	timeprecision 1ps;

	// index 1 decodes to no register and must be ignored
	localparam int REG_SPARE = 1;

	logic        clk;
	logic        arst_n;
	logic        psel, penable, pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        req_valid, req_stall;
	logic        kind;
	logic [31:0] key, value;
	logic        rsp_valid, rsp_stall;
	logic        found;
	logic [6:0]  position;
	logic [31:0] stored_value;
	logic [1:0]  status;
	logic [6:0]  entry_count;
	int          errors, answers_left, n_words, n_hits, n_added, n_dup, n_full;

	logic [31:0] used_keys [$];
	logic [31:0] corner_keys [5] = '{32'h0, 32'h1, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF};
	int          stall_mode, stall_span, stall_hold;

	sorted_set_search_insert dut (.*);
	sst_checker checker_i (.*);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// run limit, well beyond the slowest correct run
	initial begin
		#40_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	// receiver stalls in modes drawn at random, each held for a random span
	initial begin
		rsp_stall = 1'b0;
		stall_hold = 0;
		forever begin
			stall_mode = $urandom_range(0, 3);
			stall_span = $urandom_range(40, 300);
			repeat (stall_span) begin
				@(negedge clk);
				case (stall_mode)
					0: rsp_stall = 1'b0;
					1: rsp_stall = ($urandom_range(0, 3) == 0);
					2: rsp_stall = ($urandom_range(0, 3) != 0);
					default: begin
						if (stall_hold == 0) begin
							rsp_stall = ~rsp_stall;
							stall_hold = $urandom_range(1, 25);
						end else begin
							stall_hold--;
						end
					end
				endcase
			end
		end
	end

	task automatic idle_gap(input int cycles);
		repeat (cycles) begin
			@(negedge clk);
			req_valid = 1'b0;
		end
	endtask

	// present one word and hold it until the block takes it
	task automatic send_word(input logic w_kind, input logic [31:0] w_key,
			input logic [31:0] w_val);
		@(negedge clk);
		req_valid = 1'b1;
		kind = w_kind;
		key = w_key;
		value = w_val;
		if (w_kind == KIND_INSERT)
			used_keys.push_back(w_key);
		do @(posedge clk); while (req_stall);
	endtask

	// stop sending until every predicted word has come out
	task automatic drain_results();
		idle_gap(1);
		while (answers_left != 0)
			@(negedge clk);
	endtask

	task automatic reg_write(input int idx, input logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = 3'(idx * 4);
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	// keys mostly revisit earlier inserts or their neighbours to get hits
	function automatic logic [31:0] pick_key();
		int sel;
		logic [31:0] base;
		sel = $urandom_range(0, 99);
		if (used_keys.size() > 0 && sel < 55) begin
			base = used_keys[$urandom_range(0, used_keys.size() - 1)];
			if (sel < 40)
				return base;
			return $urandom_range(0, 1) ? base + 32'd1 : base - 32'd1;
		end
		if (sel < 65)
			return corner_keys[$urandom_range(0, 4)];
		return $urandom();
	endfunction

	function automatic logic [31:0] pick_value();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 32'h0;
		if (sel == 1)
			return 32'hFFFF_FFFF;
		return $urandom();
	endfunction

	// random words sent in bursts, with one full pause in longer phases
	task automatic run_phase(input int n_items, input int ins_pct);
		int i, burst;
		logic w_kind;
		burst = 0;
		for (i = 0; i < n_items; i++) begin
			if (burst == 0) begin
				idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
				burst = $urandom_range(1, 24);
			end
			burst--;
			w_kind = ($urandom_range(0, 99) < ins_pct) ? KIND_INSERT : KIND_LOOKUP;
			send_word(w_kind, pick_key(), pick_value());
			if (n_items > 300 && i == n_items / 2)
				drain_results();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		req_valid = 1'b0;
		kind = KIND_LOOKUP;
		key = '0;
		value = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// unsigned order: empty lookup, extreme keys, hits, a miss, a duplicate
		send_word(KIND_LOOKUP, 32'h0, 32'hFFFF_FFFF);
		send_word(KIND_INSERT, 32'h8000_0000, 32'hFFFF_FFFF);
		send_word(KIND_INSERT, 32'h0, 32'h0);
		idle_gap(3);
		send_word(KIND_INSERT, 32'hFFFF_FFFF, 32'hA5A5_A5A5);
		send_word(KIND_INSERT, 32'h7FFF_FFFF, 32'h5A5A_5A5A);
		send_word(KIND_INSERT, 32'h1, 32'h1);
		send_word(KIND_LOOKUP, 32'h0, 32'h0);
		send_word(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send_word(KIND_LOOKUP, 32'h8000_0000, 32'h0);
		send_word(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0);
		send_word(KIND_LOOKUP, 32'h2, 32'h0);
		send_word(KIND_INSERT, 32'h8000_0000, 32'h0000_0123);
		send_word(KIND_LOOKUP, 32'h8000_0000, 32'h0);

		// write to an unmapped address, then switch to signed order
		drain_results();
		reg_write(REG_SPARE, 32'h1);
		send_word(KIND_LOOKUP, 32'h7FFF_FFFF, 32'h0);
		drain_results();
		reg_write(REG_SIGNED_CMP, 32'h1);
		send_word(KIND_LOOKUP, 32'h8000_0000, 32'h0);
		send_word(KIND_LOOKUP, 32'hFFFF_FFFF, 32'h0);
		send_word(KIND_INSERT, 32'hFFFF_FFFE, 32'h8000_0001);
		send_word(KIND_LOOKUP, 32'hFFFF_FFFE, 32'h0);

		// random phases alternating the compare order
		run_phase(300, 12);
		drain_results();
		reg_write(REG_SIGNED_CMP, 32'h0);
		run_phase(500, 10);
		drain_results();
		reg_write(REG_SIGNED_CMP, 32'hFFFF_FFFF);
		run_phase(500, 35);
		drain_results();
		reg_write(REG_SIGNED_CMP, 32'h0);
		run_phase(631, 35);

		drain_results();
		repeat (20) @(posedge clk);
		$display("covered %0d words: %0d lookup hits, %0d new entries,", n_words, n_hits, n_added);
		$display("%0d duplicate and %0d full-store refusals, both compare orders", n_dup, n_full);
		if (errors == 0 && answers_left == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
